>>> design/h2r_pkg.sv
// Shared types and fixed-point constants for the HSL to RGB converter.
`default_nettype none

package h2r_pkg;

    // Internal fraction bits; every input is widened to this format
    localparam int IFRAC   = 24;
    localparam int FIELD_W = 16;
    localparam int CH_W    = 8;

    // Widths of the datapath
    localparam int VW    = IFRAC + 1;       // a fraction in [0, 1]
    localparam int H6W   = IFRAC + 3;       // six times a hue, [0, 6]
    localparam int TW    = IFRAC + 5;       // signed shifted hue, [-2, 8]
    localparam int SMW   = 2 * VW;          // product of two fractions
    localparam int GW    = VW + CH_W;       // lightness times 255
    localparam int SCW   = SMW + CH_W;      // ramp value times 255
    localparam int CHHW  = SCW - 2 * IFRAC; // integer part of the scaled ramp

    // Edges from the one that accepts start to the one that takes the result
    localparam int LATENCY = 7;

    // Channel lanes
    localparam int NUM_CH = 3;
    localparam int CH_R   = 0;
    localparam int CH_G   = 1;
    localparam int CH_B   = 2;

    typedef logic [VW-1:0]   frac_t;
    typedef logic [H6W-1:0]  hue6_t;
    typedef logic [SMW-1:0]  wide_t;
    typedef logic [CH_W-1:0] chan_t;

    // Fraction constants
    localparam frac_t ONE  = VW'(1) << IFRAC;
    localparam frac_t HALF = VW'(1) << (IFRAC - 1);

    // Ramp thresholds in units of one sixth of a turn
    localparam hue6_t ONE_T   = H6W'(1) << IFRAC;
    localparam hue6_t THREE_T = H6W'(3) << IFRAC;
    localparam hue6_t FOUR_T  = H6W'(4) << IFRAC;

    // Signed turn and third-of-a-turn offset for the wrap
    localparam logic signed [TW-1:0] TURN_S  = TW'(6) << IFRAC;
    localparam logic signed [TW-1:0] THIRD_S = TW'(2) << IFRAC;

    localparam chan_t CH_MAX = {CH_W{1'b1}};

endpackage

`default_nettype wire

>>> design/hsl_to_rgb_converter_unit.sv
// HSL to RGB converter: seven-stage pipeline, one colour per clock.
// done follows the valid shift register through done_reg and rises together with red, green and blue.
// Throughput: one transaction per cycle; busy is always low, nothing stalls.
// The per-channel ramp multiplier and the q multiplier each own a stage.
// Reset (rst_n low, async) clears all valid bits and the done strobe.
`default_nettype none

module hsl_to_rgb_converter_unit #(
    parameter int INPUT_FRAC_BITS = 15
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [h2r_pkg::FIELD_W-1:0]   hue,
    input  wire logic [h2r_pkg::FIELD_W-1:0]   saturation,
    input  wire logic [h2r_pkg::FIELD_W-1:0]   lightness,
    output logic                               done,
    output logic [h2r_pkg::CH_W-1:0]           red,
    output logic [h2r_pkg::CH_W-1:0]           green,
    output logic [h2r_pkg::CH_W-1:0]           blue
);

    localparam int SH = h2r_pkg::IFRAC - INPUT_FRAC_BITS;
    localparam h2r_pkg::frac_t ONE_IN = h2r_pkg::VW'(1) << INPUT_FRAC_BITS;

    // Clamp a raw field to one and widen it to the internal format
    function automatic h2r_pkg::frac_t to_internal(input logic [h2r_pkg::FIELD_W-1:0] raw);
        h2r_pkg::frac_t r;
        r = h2r_pkg::VW'(raw);
        if (r > ONE_IN)
        begin
            r = ONE_IN;
        end
        return r << SH;
    endfunction

    // Wrap a shifted hue once into [0, one turn]
    function automatic h2r_pkg::hue6_t wrap_hue(input logic signed [h2r_pkg::TW-1:0] t);
        logic signed [h2r_pkg::TW-1:0] w;
        w = t;
        if (w < 0)
        begin
            w = w + h2r_pkg::TURN_S;
        end
        if (w > h2r_pkg::TURN_S)
        begin
            w = w - h2r_pkg::TURN_S;
        end
        return w[h2r_pkg::H6W-1:0];
    endfunction

    logic accept;
    logic [h2r_pkg::LATENCY-2:0] vld_reg;
    logic done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Advance the valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[h2r_pkg::LATENCY-3:0], accept};
            done_reg <= vld_reg[h2r_pkg::LATENCY-2];
        end
    end

    // ---------------- Stage 1: clamp, widen, six times hue, q multiplicand
    h2r_pkg::frac_t h_int, s_int, l_int, m_next;
    h2r_pkg::hue6_t h6_next;
    logic           zero_next;

    h2r_pkg::hue6_t h6_s1_reg;
    h2r_pkg::frac_t s_s1_reg, l_s1_reg, m_s1_reg;
    logic           zero_s1_reg;

    always_comb
    begin
        h_int     = to_internal(hue);
        s_int     = to_internal(saturation);
        l_int     = to_internal(lightness);
        h6_next   = (h2r_pkg::H6W'(h_int) << 2) + (h2r_pkg::H6W'(h_int) << 1);
        m_next    = (l_int < h2r_pkg::HALF) ? l_int : h2r_pkg::ONE - l_int;
        zero_next = (s_int == '0);
    end

    // ---------------- Stage 2: s times m, gray level
    h2r_pkg::wide_t           sm_next;
    logic [h2r_pkg::GW-1:0]   l255;
    logic [h2r_pkg::CH_W:0]   gray_full;
    h2r_pkg::chan_t           gray_next;

    h2r_pkg::hue6_t h6_s2_reg;
    h2r_pkg::frac_t l_s2_reg;
    h2r_pkg::wide_t sm_s2_reg;
    logic           zero_s2_reg;
    h2r_pkg::chan_t gray_s2_reg;

    always_comb
    begin
        sm_next   = h2r_pkg::SMW'(s_s1_reg) * h2r_pkg::SMW'(m_s1_reg);
        l255      = (h2r_pkg::GW'(l_s1_reg) << h2r_pkg::CH_W) - h2r_pkg::GW'(l_s1_reg);
        gray_full = l255[h2r_pkg::GW-1:h2r_pkg::IFRAC];
        gray_next = (gray_full > h2r_pkg::CH_W'(h2r_pkg::CH_MAX)) ? h2r_pkg::CH_MAX
                                                                  : gray_full[h2r_pkg::CH_W-1:0];
    end

    // ---------------- Stage 3: q, p and the wrapped channel hues
    logic [h2r_pkg::VW:0]            q_sum, two_l;
    h2r_pkg::frac_t                  q_next, p_next;
    logic signed [h2r_pkg::TW-1:0]   h6_s;
    h2r_pkg::hue6_t                  t_next [h2r_pkg::NUM_CH];

    h2r_pkg::frac_t q_s3_reg, p_s3_reg;
    h2r_pkg::hue6_t t_s3_reg [h2r_pkg::NUM_CH];
    logic           zero_s3_reg;
    h2r_pkg::chan_t gray_s3_reg;

    always_comb
    begin
        q_sum  = (h2r_pkg::VW+1)'(l_s2_reg) + (h2r_pkg::VW+1)'(sm_s2_reg >> h2r_pkg::IFRAC);
        q_next = q_sum[h2r_pkg::VW-1:0];
        two_l  = {l_s2_reg, 1'b0};
        p_next = (two_l >= q_sum) ? h2r_pkg::VW'(two_l - q_sum) : '0;
        h6_s   = signed'(h2r_pkg::TW'(h6_s2_reg));
        t_next[h2r_pkg::CH_R] = wrap_hue(h6_s + h2r_pkg::THIRD_S);
        t_next[h2r_pkg::CH_G] = wrap_hue(h6_s);
        t_next[h2r_pkg::CH_B] = wrap_hue(h6_s - h2r_pkg::THIRD_S);
    end

    // ---------------- Stage 4: q minus p, ramp segment select per channel
    h2r_pkg::frac_t d_next;
    h2r_pkg::frac_t base_next [h2r_pkg::NUM_CH];
    h2r_pkg::frac_t f_next    [h2r_pkg::NUM_CH];

    h2r_pkg::frac_t d_s4_reg;
    h2r_pkg::frac_t base_s4_reg [h2r_pkg::NUM_CH];
    h2r_pkg::frac_t f_s4_reg    [h2r_pkg::NUM_CH];
    logic           zero_s4_reg;
    h2r_pkg::chan_t gray_s4_reg;

    always_comb
    begin
        d_next = (q_s3_reg >= p_s3_reg) ? q_s3_reg - p_s3_reg : '0;
        for (int i = 0; i < h2r_pkg::NUM_CH; i++)
        begin
            priority if (t_s3_reg[i] < h2r_pkg::ONE_T)
            begin
                base_next[i] = p_s3_reg;
                f_next[i]    = t_s3_reg[i][h2r_pkg::VW-1:0];
            end
            else if (t_s3_reg[i] < h2r_pkg::THREE_T)
            begin
                base_next[i] = q_s3_reg;
                f_next[i]    = '0;
            end
            else if (t_s3_reg[i] < h2r_pkg::FOUR_T)
            begin
                base_next[i] = p_s3_reg;
                f_next[i]    = h2r_pkg::VW'(h2r_pkg::FOUR_T - t_s3_reg[i]);
            end
            else
            begin
                base_next[i] = p_s3_reg;
                f_next[i]    = '0;
            end
        end
    end

    // ---------------- Stage 5: ramp slope multiply per channel
    h2r_pkg::wide_t prod_next [h2r_pkg::NUM_CH];

    h2r_pkg::wide_t prod_s5_reg [h2r_pkg::NUM_CH];
    h2r_pkg::frac_t base_s5_reg [h2r_pkg::NUM_CH];
    logic           zero_s5_reg;
    h2r_pkg::chan_t gray_s5_reg;

    always_comb
    begin
        for (int i = 0; i < h2r_pkg::NUM_CH; i++)
        begin
            prod_next[i] = h2r_pkg::SMW'(d_s4_reg) * h2r_pkg::SMW'(f_s4_reg[i]);
        end
    end

    // ---------------- Stage 6: add the ramp base
    h2r_pkg::wide_t val_next [h2r_pkg::NUM_CH];

    h2r_pkg::wide_t val_s6_reg [h2r_pkg::NUM_CH];
    logic           zero_s6_reg;
    h2r_pkg::chan_t gray_s6_reg;

    always_comb
    begin
        for (int i = 0; i < h2r_pkg::NUM_CH; i++)
        begin
            val_next[i] = (h2r_pkg::SMW'(base_s5_reg[i]) << h2r_pkg::IFRAC) + prod_s5_reg[i];
        end
    end

    // ---------------- Stage 7: scale by 255, truncate, saturate, pick gray
    logic [h2r_pkg::SCW-1:0]  scaled [h2r_pkg::NUM_CH];
    logic [h2r_pkg::CHHW-1:0] chan_hi [h2r_pkg::NUM_CH];
    h2r_pkg::chan_t           chan_next [h2r_pkg::NUM_CH];

    h2r_pkg::chan_t red_reg, green_reg, blue_reg;

    always_comb
    begin
        for (int i = 0; i < h2r_pkg::NUM_CH; i++)
        begin
            scaled[i]  = (h2r_pkg::SCW'(val_s6_reg[i]) << h2r_pkg::CH_W)
                       - h2r_pkg::SCW'(val_s6_reg[i]);
            chan_hi[i] = scaled[i][h2r_pkg::SCW-1:2*h2r_pkg::IFRAC];
            if (zero_s6_reg)
            begin
                chan_next[i] = gray_s6_reg;
            end
            else if (chan_hi[i] > h2r_pkg::CHHW'(h2r_pkg::CH_MAX))
            begin
                chan_next[i] = h2r_pkg::CH_MAX;
            end
            else
            begin
                chan_next[i] = chan_hi[i][h2r_pkg::CH_W-1:0];
            end
        end
    end

    // Hold the payload registers of every stage
    always_ff @(posedge clk)
    begin
        h6_s1_reg   <= h6_next;
        s_s1_reg    <= s_int;
        l_s1_reg    <= l_int;
        m_s1_reg    <= m_next;
        zero_s1_reg <= zero_next;

        h6_s2_reg   <= h6_s1_reg;
        l_s2_reg    <= l_s1_reg;
        sm_s2_reg   <= sm_next;
        zero_s2_reg <= zero_s1_reg;
        gray_s2_reg <= gray_next;

        q_s3_reg    <= q_next;
        p_s3_reg    <= p_next;
        zero_s3_reg <= zero_s2_reg;
        gray_s3_reg <= gray_s2_reg;

        d_s4_reg    <= d_next;
        zero_s4_reg <= zero_s3_reg;
        gray_s4_reg <= gray_s3_reg;

        zero_s5_reg <= zero_s4_reg;
        gray_s5_reg <= gray_s4_reg;

        zero_s6_reg <= zero_s5_reg;
        gray_s6_reg <= gray_s5_reg;

        for (int i = 0; i < h2r_pkg::NUM_CH; i++)
        begin
            t_s3_reg[i]    <= t_next[i];
            base_s4_reg[i] <= base_next[i];
            f_s4_reg[i]    <= f_next[i];
            prod_s5_reg[i] <= prod_next[i];
            base_s5_reg[i] <= base_s4_reg[i];
            val_s6_reg[i]  <= val_next[i];
        end

        red_reg   <= chan_next[h2r_pkg::CH_R];
        green_reg <= chan_next[h2r_pkg::CH_G];
        blue_reg  <= chan_next[h2r_pkg::CH_B];
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    // Every accepted transaction yields a result after the pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(h2r_pkg::LATENCY) done)
        else $error("result missing after accepted transaction");

    // No result without a matching accepted transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, h2r_pkg::LATENCY))
        else $error("result without a matching transaction");

    // Zero saturation gives a gray result
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (saturation == '0)) |-> ##(h2r_pkg::LATENCY)
        (done && (red == green) && (green == blue)))
        else $error("zero saturation produced unequal channels");

endmodule

`default_nettype wire
